FILE: rtl/lse_pkg.sv
package lse_pkg;

    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int ONE_Q16             = 65536;
    localparam int HEART_BIAS_Q16      = 91750;

    // sine pipeline: squaring, four Horner steps, final scale
    localparam int SINE_LAT = 6;

    // square root and divider, two result bits per stage
    localparam int STEPS_PER_STAGE = 2;
    localparam int SQRT_ITERS      = 17;
    localparam int DIV_ITERS       = 18;
    localparam int SQRT_STAGES     = (SQRT_ITERS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int DIV_STAGES      = (DIV_ITERS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int HDIV_LAT        = SQRT_STAGES + DIV_STAGES + 2;

    // input, phase, sines, heart term, profile, scale, product, output
    localparam int PIPE_LAT = 2 + SINE_LAT + HDIV_LAT + 4;

    localparam logic [1:0] CFG_OUTER = 2'd0;
    localparam logic [1:0] CFG_INNER = 2'd1;
    localparam logic [1:0] CFG_LOBES = 2'd2;

endpackage

FILE: rtl/lse_sine.sv
module lse_sine (
    input  logic               i_clk,
    input  logic [16:0]        i_phase,
    output logic signed [17:0] o_val
);

    localparam logic signed [33:0] K9 = 34'sd172273;
    localparam logic signed [33:0] HORNER_ADD [4] = '{
        -34'sd5026995, 34'sd85569305, -34'sd693598669, 34'sd1686629713
    };

    function automatic logic signed [33:0] horner_step(
        input logic signed [33:0] acc,
        input logic [16:0]        t2,
        input logic signed [33:0] addc
    );
        logic signed [51:0] prod;
        prod = acc * $signed({1'b0, t2});
        return addc + $signed(prod[49:16]);
    endfunction

    function automatic logic [16:0] ONE_Q17_M(input logic [15:0] x);
        return 17'(lse_pkg::ONE_Q16) - {1'b0, x};
    endfunction

    logic [1:0]  quad;
    logic [15:0] xoff;
    logic [16:0] t0;
    logic [33:0] tsq;
    logic [34:0] tsq_rnd;

    logic [16:0]        r_t   [1:5];
    logic               r_neg [1:5];
    logic [16:0]        r_t2  [1:4];
    logic signed [33:0] r_acc [2:5];
    logic signed [33:0] n_acc [2:5];
    logic signed [17:0] r_res;
    logic signed [17:0] n_res;

    logic signed [51:0] fin_prod;
    logic signed [51:0] fin_rnd;
    logic signed [21:0] fin_sh;
    logic [16:0]        mag;

    // fold the phase into the first quadrant
    assign quad    = i_phase[16:15];
    assign xoff    = {i_phase[14:0], 1'b0};
    assign t0      = quad[0] ? 17'(ONE_Q17_M(xoff)) : {1'b0, xoff};
    assign tsq     = t0 * t0;
    assign tsq_rnd = {1'b0, tsq} + 35'd32768;

    always_comb begin
        n_acc[2] = horner_step(K9, r_t2[1], HORNER_ADD[0]);
        for (int k = 3; k <= 5; k++) begin
            n_acc[k] = horner_step(r_acc[k-1], r_t2[k-1], HORNER_ADD[k-2]);
        end
    end

    assign fin_prod = r_acc[5] * $signed({1'b0, r_t[5]});
    assign fin_rnd  = fin_prod + 52'sd536870912;
    assign fin_sh   = $signed(fin_rnd[51:30]);

    always_comb begin
        if (fin_sh < 22'sd0) begin
            mag = '0;
        end else if (fin_sh > 22'sd65536) begin
            mag = 17'(lse_pkg::ONE_Q16);
        end else begin
            mag = fin_sh[16:0];
        end
        n_res = r_neg[5] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge i_clk) begin
        r_t[1]   <= t0;
        r_neg[1] <= quad[1];
        r_t2[1]  <= tsq_rnd[32:16];
        for (int k = 2; k <= 5; k++) begin
            r_t[k]   <= r_t[k-1];
            r_neg[k] <= r_neg[k-1];
            r_acc[k] <= n_acc[k];
        end
        for (int k = 2; k <= 4; k++) begin
            r_t2[k] <= r_t2[k-1];
        end
        r_res <= n_res;
    end

    assign o_val = r_res;

endmodule

FILE: rtl/lse_hdiv.sv
module lse_hdiv (
    input  logic               i_clk,
    input  logic signed [17:0] i_sin,
    input  logic signed [17:0] i_cos,
    output logic signed [18:0] o_term
);

    localparam int SqSt = lse_pkg::SQRT_STAGES;
    localparam int DvSt = lse_pkg::DIV_STAGES;
    localparam int Per  = lse_pkg::STEPS_PER_STAGE;

    typedef struct packed {
        logic [20:0] rem;
        logic [16:0] root;
        logic [33:0] x;
    } t_sq;

    typedef struct packed {
        logic [18:0] rem;
        logic [17:0] q;
        logic [17:0] x;
    } t_dv;

    function automatic t_sq sq_steps(input t_sq st, input int cnt);
        t_sq         o;
        logic [20:0] trial;
        o = st;
        for (int m = 0; m < Per; m++) begin
            if (m < cnt) begin
                o.rem = {o.rem[18:0], o.x[33:32]};
                o.x   = {o.x[31:0], 2'b00};
                trial = {2'b00, o.root, 2'b01};
                if (o.rem >= trial) begin
                    o.rem  = o.rem - trial;
                    o.root = {o.root[15:0], 1'b1};
                end else begin
                    o.root = {o.root[15:0], 1'b0};
                end
            end
        end
        return o;
    endfunction

    function automatic t_dv dv_steps(input t_dv st, input logic [17:0] d, input int cnt);
        t_dv o;
        o = st;
        for (int m = 0; m < Per; m++) begin
            if (m < cnt) begin
                o.rem = {o.rem[17:0], o.x[17]};
                o.x   = {o.x[16:0], 1'b0};
                if (o.rem >= {1'b0, d}) begin
                    o.rem = o.rem - {1'b0, d};
                    o.q   = {o.q[16:0], 1'b1};
                end else begin
                    o.q   = {o.q[16:0], 1'b0};
                end
            end
        end
        return o;
    endfunction

    function automatic int stage_cnt(input int total, input int j);
        int c;
        c = total - Per * (j - 1);
        if (c > Per) c = Per;
        return c;
    endfunction

    t_sq                sq_init;
    t_sq                r_sq  [1:SqSt];
    t_sq                n_sq  [1:SqSt];
    logic signed [17:0] r_sc  [1:SqSt];
    logic [16:0]        s_pos;

    logic signed [35:0] num;
    logic signed [35:0] num_abs;
    logic signed [18:0] den;
    logic [32:0]        r_mag;
    logic               r_mneg;
    logic [17:0]        r_md;

    t_dv                dv_init;
    t_dv                r_dv   [1:DvSt];
    t_dv                n_dv   [1:DvSt];
    logic [17:0]        r_dd   [1:DvSt];
    logic               r_dneg [1:DvSt];
    logic signed [18:0] r_term;

    assign s_pos   = i_sin[17] ? '0 : i_sin[16:0];
    assign sq_init = '{rem: '0, root: '0, x: {1'b0, s_pos, 16'h0000}};

    always_comb begin
        n_sq[1] = sq_steps(sq_init, stage_cnt(lse_pkg::SQRT_ITERS, 1));
        for (int j = 2; j <= SqSt; j++) begin
            n_sq[j] = sq_steps(r_sq[j-1], stage_cnt(lse_pkg::SQRT_ITERS, j));
        end
    end

    // c * sqrt(s) over (1.4 - c), divided as magnitudes
    assign num     = r_sc[SqSt] * $signed({1'b0, r_sq[SqSt].root});
    assign num_abs = num[35] ? -num : num;
    assign den     = 19'(lse_pkg::HEART_BIAS_Q16) - 19'(r_sc[SqSt]);
    assign dv_init = '{rem: {4'b0000, r_mag[32:18]}, q: '0, x: r_mag[17:0]};

    always_comb begin
        n_dv[1] = dv_steps(dv_init, r_md, stage_cnt(lse_pkg::DIV_ITERS, 1));
        for (int j = 2; j <= DvSt; j++) begin
            n_dv[j] = dv_steps(r_dv[j-1], r_dd[j-1], stage_cnt(lse_pkg::DIV_ITERS, j));
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq[1] <= n_sq[1];
        r_sc[1] <= i_cos;
        for (int j = 2; j <= SqSt; j++) begin
            r_sq[j] <= n_sq[j];
            r_sc[j] <= r_sc[j-1];
        end
        r_mag   <= num_abs[32:0];
        r_mneg  <= num[35];
        r_md    <= den[17:0];
        r_dv[1]   <= n_dv[1];
        r_dd[1]   <= r_md;
        r_dneg[1] <= r_mneg;
        for (int j = 2; j <= DvSt; j++) begin
            r_dv[j]   <= n_dv[j];
            r_dd[j]   <= r_dd[j-1];
            r_dneg[j] <= r_dneg[j-1];
        end
        r_term <= r_dneg[DvSt] ? -$signed({1'b0, r_dv[DvSt].q})
                               : $signed({1'b0, r_dv[DvSt].q});
    end

    assign o_term = r_term;

endmodule

FILE: rtl/lobed_surface_vertex_eval.sv
// Lobed surface vertex evaluator. Takes one (u, v) coordinate pair per clock while start is
// high; busy stays low, so every cycle can carry an item. The vertex appears on o_pos_x/y/z
// with o_strobe high for one cycle once the item has passed the whole pipeline, in order.
// The receiver cannot stall the block, so results must be captured when the strobe is high.
// Latency is set mainly by the square-root and divider pipeline of the heart profile
// (20 stages, at most two result bits each) behind the 6-stage sine polynomial units.
// Radius and lobe count registers are written through the cfg channel, which is always
// ready; write them only while no item is in flight.
module lobed_surface_vertex_eval #(
    parameter int COORD_FRAC_BITS = lse_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [COORD_FRAC_BITS:0]   i_coord_u,
    input  logic [COORD_FRAC_BITS:0]   i_coord_v,
    output logic                       o_strobe,
    output logic signed [20:0]         o_pos_x,
    output logic signed [20:0]         o_pos_y,
    output logic signed [20:0]         o_pos_z,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [15:0]                i_cfg_data
);

    localparam int PipeLat = lse_pkg::PIPE_LAT;
    localparam int SideLen = lse_pkg::HDIV_LAT;
    localparam logic [COORD_FRAC_BITS:0] CoordOne = {1'b1, {COORD_FRAC_BITS{1'b0}}};

    typedef struct packed {
        logic [17:0] c;
        logic [17:0] dir_x;
        logic [17:0] dir_z;
        logic [17:0] rad;
    } t_side;

    function automatic logic [20:0] sat_pos(input logic signed [56:0] p);
        logic signed [56:0] rnd;
        logic signed [24:0] sh;
        rnd = p + 57'sd2147483648;
        sh  = $signed(rnd[56:32]);
        if (sh > 25'sd1048575) begin
            return 21'h0FFFFF;
        end else if (sh < -25'sd1048576) begin
            return 21'h100000;
        end else begin
            return sh[20:0];
        end
    endfunction

    logic accept;
    logic [PipeLat-1:0] r_vld;

    logic [15:0] r_outer;
    logic [15:0] r_inner;
    logic [6:0]  r_lobes;

    logic [COORD_FRAC_BITS:0] u_cl;
    logic [COORD_FRAC_BITS:0] v_cl;
    logic [16:0] u16;
    logic [16:0] v16;
    logic [16:0] r_a_u;
    logic [16:0] r_a_v;

    logic [23:0] frac_prod;
    logic [16:0] r_ph_v;
    logic [16:0] r_ph_vc;
    logic [16:0] r_ph_u;
    logic [16:0] r_ph_uc;
    logic [16:0] r_ph_w;

    logic signed [17:0] sin_v;
    logic signed [17:0] cos_v;
    logic signed [17:0] sin_u;
    logic signed [17:0] cos_u;
    logic signed [17:0] wall;
    logic signed [18:0] term;

    logic signed [17:0] s_pos;
    logic signed [35:0] dx_rnd;
    logic signed [35:0] dz_rnd;
    logic signed [16:0] rdiff;
    logic signed [34:0] wprod;
    logic signed [35:0] rsum;
    t_side              n_side;
    t_side              r_side [SideLen];
    t_side              side_end;

    logic signed [20:0] r_q1_prof;
    t_side              r_q1_side;
    logic signed [38:0] r_q2_scale;
    t_side              r_q2_side;
    logic signed [56:0] r_q3_x;
    logic signed [56:0] r_q3_y;
    logic signed [56:0] r_q3_z;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer <= 16'd256;
            r_inner <= 16'd128;
            r_lobes <= 7'd8;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lse_pkg::CFG_OUTER: r_outer <= i_cfg_data;
                lse_pkg::CFG_INNER: r_inner <= i_cfg_data;
                lse_pkg::CFG_LOBES: r_lobes <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PipeLat-2:0], accept};
        end
    end

    // clamp to 1.0 and bring to Q1.16
    assign u_cl = (i_coord_u > CoordOne) ? CoordOne : i_coord_u;
    assign v_cl = (i_coord_v > CoordOne) ? CoordOne : i_coord_v;

    generate
        if (COORD_FRAC_BITS >= 16) begin : g_down
            assign u16 = 17'(u_cl >> (COORD_FRAC_BITS - 16));
            assign v16 = 17'(v_cl >> (COORD_FRAC_BITS - 16));
        end else begin : g_up
            assign u16 = 17'(u_cl) << (16 - COORD_FRAC_BITS);
            assign v16 = 17'(v_cl) << (16 - COORD_FRAC_BITS);
        end
    endgenerate

    assign frac_prod = r_a_u * r_lobes;

    always_ff @(posedge i_clk) begin
        r_a_u   <= u16;
        r_a_v   <= v16;
        r_ph_v  <= r_a_v;
        r_ph_vc <= 17'(r_a_v + 17'h08000);
        r_ph_u  <= {r_a_u[15:0], 1'b0};
        r_ph_uc <= 17'({r_a_u[15:0], 1'b0} + 17'h08000);
        r_ph_w  <= {1'b0, frac_prod[15:0]};
    end

    lse_sine u_sin_v (.i_clk(i_clk), .i_phase(r_ph_v),  .o_val(sin_v));
    lse_sine u_cos_v (.i_clk(i_clk), .i_phase(r_ph_vc), .o_val(cos_v));
    lse_sine u_sin_u (.i_clk(i_clk), .i_phase(r_ph_u),  .o_val(sin_u));
    lse_sine u_cos_u (.i_clk(i_clk), .i_phase(r_ph_uc), .o_val(cos_u));
    lse_sine u_wall  (.i_clk(i_clk), .i_phase(r_ph_w),  .o_val(wall));

    lse_hdiv u_hdiv (
        .i_clk  (i_clk),
        .i_sin  (sin_v),
        .i_cos  (cos_v),
        .o_term (term)
    );

    // cosine, direction and blended wall radius, then hold them beside the divider
    assign s_pos  = sin_v[17] ? '0 : sin_v;
    assign dx_rnd = sin_u * s_pos + 36'sd32768;
    assign dz_rnd = cos_u * s_pos + 36'sd32768;
    assign rdiff  = $signed({1'b0, r_outer}) - $signed({1'b0, r_inner});
    assign wprod  = wall * rdiff;
    assign rsum   = $signed({2'b00, r_inner, 16'h8000}) + 36'(wprod);

    always_comb begin
        n_side.c     = cos_v;
        n_side.dir_x = 18'(dx_rnd >>> 16);
        n_side.dir_z = 18'(dz_rnd >>> 16);
        n_side.rad   = 18'(rsum >>> 16);
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side;
        for (int k = 1; k < SideLen; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    assign side_end = r_side[SideLen-1];

    always_ff @(posedge i_clk) begin
        r_q1_prof  <= 21'sd131072 + (21'($signed(side_end.c)) <<< 1) - 21'(term);
        r_q1_side  <= side_end;
        r_q2_scale <= r_q1_prof * $signed(r_q1_side.rad);
        r_q2_side  <= r_q1_side;
        r_q3_x     <= r_q2_scale * $signed(r_q2_side.dir_x);
        r_q3_y     <= r_q2_scale * $signed(r_q2_side.c);
        r_q3_z     <= r_q2_scale * $signed(r_q2_side.dir_z);
        o_pos_x    <= sat_pos(r_q3_x);
        o_pos_y    <= sat_pos(r_q3_y);
        o_pos_z    <= sat_pos(r_q3_z);
    end

    assign o_strobe = r_vld[PipeLat-1];

    a_strobe_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, PipeLat))
        else $error("result without a matching item");

    a_pole_on_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(start && !busy && i_coord_v == '0, PipeLat))
            |-> (o_pos_x == 21'sd0 && o_pos_z == 21'sd0))
        else $error("pole vertex off axis: direction and divider out of step");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe after reset");

endmodule

FILE: tb/lobed_surface_vertex_eval_tb.sv
`timescale 1ns / 100ps

module lobed_surface_vertex_eval_tb;

    localparam int          PIPE_WAIT   = 40;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          ITEM_TOTAL  = 1850;
    localparam logic [1:0]  CFG_SPARE   = 2'd3;

    typedef struct {
        logic signed [20:0] x;
        logic signed [20:0] y;
        logic signed [20:0] z;
    } t_vertex;

    class t_vertex_scoreboard;
        t_vertex     vertex_q[$];
        int          n_errors;
        longint      outer_r;
        longint      inner_r;
        longint      lobes;

        function new();
            n_errors = 0;
            outer_r  = 256;
            inner_r  = 128;
            lobes    = 8;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                lse_pkg::CFG_OUTER: outer_r = data;
                lse_pkg::CFG_INNER: inner_r = data;
                lse_pkg::CFG_LOBES: lobes   = data[6:0];
                default: ;
            endcase
        endfunction

        static function longint round_shift(longint x, int n);
            return (x + (64'sd1 <<< (n - 1))) >>> n;
        endfunction

        static function longint quarter_wave(longint t);
            longint t2, acc, res;
            t2  = round_shift(t * t, 16);
            acc = 172273;
            acc = -5026995   + ((acc * t2) >>> 16);
            acc = 85569305   + ((acc * t2) >>> 16);
            acc = -693598669 + ((acc * t2) >>> 16);
            acc = 1686629713 + ((acc * t2) >>> 16);
            res = round_shift(acc * t, 30);
            if (res < 0) res = 0;
            if (res > lse_pkg::ONE_Q16) res = lse_pkg::ONE_Q16;
            return res;
        endfunction

        // phase: 2^17 units per full turn
        static function longint sine_of(longint p);
            logic [16:0] ph;
            longint      t, s, x;
            ph = p[16:0];
            x  = {ph[14:0], 1'b0};
            t  = ph[15] ? lse_pkg::ONE_Q16 - x : x;
            s  = quarter_wave(t);
            return ph[16] ? -s : s;
        endfunction

        static function longint int_sqrt(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b;
                    r  = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return longint'(r);
        endfunction

        static function logic signed [20:0] clip(longint x);
            if (x > 1048575) x = 1048575;
            if (x < -1048576) x = -1048576;
            return x[20:0];
        endfunction

        function void note_item(logic [16:0] raw_u, logic [16:0] raw_v);
            longint  u, v, c, s, root, term, prof, st, ct, dx, dz, frac, wall, rad, scale;
            t_vertex e;
            u     = (raw_u > lse_pkg::ONE_Q16) ? lse_pkg::ONE_Q16 : raw_u;
            v     = (raw_v > lse_pkg::ONE_Q16) ? lse_pkg::ONE_Q16 : raw_v;
            c     = sine_of(v + 32768);
            s     = sine_of(v);
            if (s < 0) s = 0;
            root  = int_sqrt(longint'(s) << 16);
            term  = (c * root) / (lse_pkg::HEART_BIAS_Q16 - c);
            prof  = 2 * lse_pkg::ONE_Q16 + 2 * c - term;
            st    = sine_of(u << 1);
            ct    = sine_of((u << 1) + 32768);
            dx    = round_shift(st * s, 16);
            dz    = round_shift(ct * s, 16);
            frac  = (u * lobes) & 64'hFFFF;
            wall  = sine_of(frac);
            rad   = round_shift((inner_r <<< 16) + wall * (outer_r - inner_r), 16);
            scale = prof * rad;
            e.x   = clip(round_shift(scale * dx, 32));
            e.y   = clip(round_shift(scale * c, 32));
            e.z   = clip(round_shift(scale * dz, 32));
            vertex_q.push_back(e);
        endfunction

        function void check_vertex(logic signed [20:0] x, logic signed [20:0] y,
                                   logic signed [20:0] z);
            t_vertex e;
            if (vertex_q.size() == 0) begin
                $error("vertex with none expected: x=%0d y=%0d z=%0d", x, y, z);
                n_errors++;
                return;
            end
            e = vertex_q.pop_front();
            if (x !== e.x) begin
                $error("pos_x expected %0d actual %0d", e.x, x);
                n_errors++;
            end
            if (y !== e.y) begin
                $error("pos_y expected %0d actual %0d", e.y, y);
                n_errors++;
            end
            if (z !== e.z) begin
                $error("pos_z expected %0d actual %0d", e.z, z);
                n_errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [16:0]        i_coord_u;
    logic [16:0]        i_coord_v;
    logic               o_strobe;
    logic signed [20:0] o_pos_x;
    logic signed [20:0] o_pos_y;
    logic signed [20:0] o_pos_z;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    t_vertex_scoreboard sb;
    int                 n_sent;
    int                 n_cycles = 0;

    lobed_surface_vertex_eval uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_coord_u   (i_coord_u),
        .i_coord_v   (i_coord_v),
        .o_strobe    (o_strobe),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_pos_z     (o_pos_z),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_vertex(o_pos_x, o_pos_y, o_pos_z);
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("lobed_surface_vertex_eval_tb: errors");
            $finish;
        end
    end

    task automatic send_item(logic [16:0] u, logic [16:0] v);
        int idle_pct;
        start     <= 1'b1;
        i_coord_u <= u;
        i_coord_v <= v;
        do @(posedge i_clk); while (busy);
        sb.note_item(u, v);
        n_sent++;
        // sender idling: 31 %, then 54 %, then none
        idle_pct = (n_sent < ITEM_TOTAL / 3) ? 31 : (n_sent < 2 * ITEM_TOTAL / 3) ? 54 : 0;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop start and let every item in flight come out
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.vertex_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_WAIT) @(posedge i_clk);
    endtask

    task automatic random_items(int n);
        logic [16:0] u, v;
        repeat (n) begin
            if ($urandom_range(9) == 0) begin
                u = 17'($urandom_range(131071));
                v = 17'($urandom_range(131071));
            end else begin
                u = 17'($urandom_range(65536));
                v = 17'($urandom_range(65536));
            end
            send_item(u, v);
        end
    endtask

    task automatic set_walls(logic [15:0] outer, logic [15:0] inner, logic [6:0] lobes);
        logic [15:0] upper;
        upper = 16'($urandom);
        write_reg(lse_pkg::CFG_OUTER, outer);
        write_reg(lse_pkg::CFG_INNER, inner);
        // upper data bits are not part of the lobe count
        write_reg(lse_pkg::CFG_LOBES, {upper[15:7], lobes});
    endtask

    initial begin
        sb          = new();
        n_sent      = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_coord_u   = '0;
        i_coord_v   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = lse_pkg::CFG_OUTER;
        i_cfg_data  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: corners, poles, equator, clamped coordinates, u at one
        send_item(17'd0,      17'd0);
        send_item(17'd65536,  17'd65536);
        send_item(17'h1FFFF,  17'h1FFFF);
        send_item(17'd0,      17'd65536);
        send_item(17'd65536,  17'd0);
        send_item(17'd32768,  17'd32768);
        send_item(17'd16384,  17'd49152);
        send_item(17'd65536,  17'd32768);
        send_item(17'd1,      17'd1);
        send_item(17'd65535,  17'd65535);
        send_item(17'd98304,  17'd12345);
        send_item(17'd8192,   17'd40000);
        send_item(17'd4096,   17'd60000);
        send_item(17'h0AAAA,  17'h15555);
        send_item(17'h15555,  17'h0AAAA);
        random_items(300);
        drain();

        set_walls(16'hFFFF, 16'h0000, 7'd64);
        random_items(300);
        drain();

        // inner above outer: blend runs downward
        set_walls(16'h0000, 16'hFFFF, 7'd1);
        random_items(300);
        drain();

        // zero lobes, plus a write to an unused index
        set_walls(16'hFFFF, 16'hFFFF, 7'd0);
        write_reg(CFG_SPARE, 16'h1234);
        random_items(300);
        drain();

        set_walls(16'd300, 16'd1000, 7'd127);
        random_items(300);
        drain();

        set_walls(16'($urandom), 16'($urandom), 7'($urandom_range(64, 1)));
        random_items(335);
        drain();

        if (sb.n_errors == 0) begin
            $display("lobed_surface_vertex_eval_tb: clean");
        end else begin
            $display("lobed_surface_vertex_eval_tb: errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lse_pkg.sv
rtl/lse_sine.sv
rtl/lse_hdiv.sv
rtl/lobed_surface_vertex_eval.sv
tb/lobed_surface_vertex_eval_tb.sv
